// File: hw/rtl/tcit_pkg.sv
package tcit_pkg;

  // Default sizes
  localparam int EVENT_DEPTH_DEF     = 32;
  localparam int REG_STORE_BYTES_DEF = 65536;
  localparam int ARG_SLOTS_DEF       = 8;

  // Bus item kinds
  typedef enum logic [2:0] {
    REQ_START_WRITE = 3'd0,
    REQ_START_READ  = 3'd1,
    REQ_WRITE_BYTE  = 3'd2,
    REQ_READ_BYTE   = 3'd3,
    REQ_TOUCH       = 3'd4
  } req_type_t;

  // Source of the returned read byte
  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_RING   = 2'd1,
    SRC_STORE  = 2'd2
  } rd_src_t;

  // Command codes
  localparam logic [7:0] CMD_STATUS_A    = 8'hA3;
  localparam logic [7:0] CMD_STATUS_B    = 8'hA4;
  localparam logic [7:0] CMD_STATUS_C    = 8'hFC;
  localparam logic [7:0] CMD_CALIBRATE   = 8'hA7;
  localparam logic [7:0] CMD_WRITE_REG   = 8'hB6;
  localparam logic [7:0] CMD_GPIO_QUERY  = 8'hCF;
  localparam logic [7:0] CMD_WINDOW      = 8'hD0;
  localparam logic [7:0] CMD_EVENT_A     = 8'h85;
  localparam logic [7:0] CMD_EVENT_B     = 8'h86;
  localparam logic [7:0] CMD_EVENT_C     = 8'h87;

  // Register addresses behind the register-write command
  localparam logic [7:0] REG_ADDR_HI     = 8'h00;
  localparam logic [7:0] REG_SYS_RESET   = 8'h28;
  localparam logic [7:0] SYS_RESET_VAL   = 8'h80;
  localparam logic [7:0] REG_EVENT_COUNT = 8'h23;
  localparam logic [7:0] GPIO_QUERY_ARG  = 8'h01;

  // Event types and status codes
  localparam logic [7:0] EV_HOVER        = 8'h00;
  localparam logic [7:0] EV_PRESS        = 8'h03;
  localparam logic [7:0] EV_RELEASE      = 8'h04;
  localparam logic [7:0] EV_HOLD         = 8'h05;
  localparam logic [7:0] EV_CALIBRATED   = 8'h0F;
  localparam logic [7:0] EV_READY        = 8'h10;
  localparam logic [7:0] EV_STATUS       = 8'h16;
  localparam logic [7:0] EV_GPIO         = 8'h20;
  localparam logic [7:0] ST_STATUS_A     = 8'h01;
  localparam logic [7:0] ST_STATUS_B     = 8'h02;
  localparam logic [7:0] ST_STATUS_C     = 8'h04;
  localparam logic [7:0] ST_CALIBRATED   = 8'h05;
  localparam logic [7:0] ST_GPIO         = 8'h01;

  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic        touch_down;
  } item_t;

  typedef struct packed {
    rd_src_t    src;
    logic [2:0] byte_sel;
    logic [7:0] direct;
    logic [4:0] pending;
  } resp_info_t;

  // Saturating byte counter increment
  function automatic logic [16:0] sat_inc(input logic [16:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 17'd1;
  endfunction

  // Status event: type in byte 0, status in byte 1
  function automatic logic [63:0] make_event(input logic [7:0] ev_type,
                                             input logic [7:0] status);
    return {48'h0, status, ev_type};
  endfunction

  // Touch event with packed coordinates
  function automatic logic [63:0] touch_event(input logic [7:0]  ev_type,
                                              input logic [11:0] x,
                                              input logic [11:0] y,
                                              input logic        down);
    return {8'h00, 7'h00, down, 8'h00, 7'h00, down,
            x[3:0], y[3:0], y[11:4], x[11:4], ev_type};
  endfunction

  // Power-on contents of the register store (firmware info bytes)
  function automatic logic [7:0] store_init(input logic [15:0] addr);
    logic [7:0] v;
    v = 8'h00;
    case (addr)
      16'h0060: v = 8'h70;
      16'h0070: v = 8'h32;
      16'h0073: v = 8'h01;
      default:  v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/tcit_ram.sv
module tcit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tcit_core.sv
module tcit_core #(
  parameter int EVENT_DEPTH     = tcit_pkg::EVENT_DEPTH_DEF,
  parameter int REG_STORE_BYTES = tcit_pkg::REG_STORE_BYTES_DEF,
  parameter int ARG_SLOTS       = tcit_pkg::ARG_SLOTS_DEF,
  localparam int RIW = $clog2(EVENT_DEPTH),
  localparam int SAW = $clog2(REG_STORE_BYTES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  tcit_pkg::item_t      item,
  output tcit_pkg::resp_info_t info,
  output logic                 store_we,
  output logic [SAW-1:0]       store_waddr,
  output logic [7:0]           store_wdata,
  output logic [SAW-1:0]       store_raddr,
  output logic                 ring_we,
  output logic [RIW-1:0]       ring_waddr,
  output logic [63:0]          ring_wdata,
  output logic [RIW-1:0]       ring_raddr
);
  import tcit_pkg::*;

  localparam int AIW = $clog2(ARG_SLOTS);
  localparam logic [RIW-1:0] LAST_IDX    = RIW'(EVENT_DEPTH - 1);
  localparam logic [RIW-1:0] FULL_CNT    = RIW'(EVENT_DEPTH - 1);
  localparam logic [17:0]    STORE_LIMIT = 18'(REG_STORE_BYTES);
  localparam logic [16:0]    ARG_LIMIT   = 17'(ARG_SLOTS);

  // Transaction state
  logic        cmd_valid, cmd_valid_next;
  logic [7:0]  cmd_code, cmd_code_next;
  logic [16:0] arg_count, arg_count_next;
  logic [16:0] read_count, read_count_next;
  logic [7:0]  arg_bytes [ARG_SLOTS];
  logic        arg_we;

  // Event ring pointers
  logic [RIW-1:0]         ring_rd, ring_rd_next;
  logic [RIW-1:0]         ring_wr, ring_wr_next;
  logic [RIW-1:0]         ring_cnt, ring_cnt_next;
  logic [EVENT_DEPTH-1:0] ring_valid;

  // Touch tracking
  logic [11:0] last_x, last_x_next;
  logic [11:0] last_y, last_y_next;
  logic        is_touched, is_touched_next;
  logic        was_touched, was_touched_next;

  logic        push_req;
  logic [63:0] push_data;
  logic [7:0]  touch_type;
  logic        touch_changed;
  logic        event_cmd;
  logic        count_read_cmd;
  logic [15:0] win_base;
  logic [17:0] wpos, rpos;
  logic        wpos_ok, rpos_ok;
  logic [RIW+8:0] cnt_x2_ext;
  logic [RIW+4:0] pending_ext;
  rd_src_t     rd_src;
  logic [7:0]  rd_direct;

  function automatic logic [RIW-1:0] idx_inc(input logic [RIW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // Register window addresses
  assign win_base = {arg_bytes[0], arg_bytes[1]};
  assign wpos     = {2'b00, win_base} + {1'b0, arg_count} - 18'd2;
  assign rpos     = {2'b00, win_base} + {1'b0, read_count} - 18'd1;
  assign wpos_ok  = wpos < STORE_LIMIT;
  assign rpos_ok  = rpos < STORE_LIMIT;

  assign event_cmd = (cmd_code == CMD_EVENT_A) || (cmd_code == CMD_EVENT_B) ||
                     (cmd_code == CMD_EVENT_C);
  assign count_read_cmd = (cmd_code == CMD_WRITE_REG) && (arg_count == 17'd2) &&
                          (arg_bytes[0] == REG_ADDR_HI) &&
                          (arg_bytes[1] == REG_EVENT_COUNT);

  assign touch_changed = (item.touch_x != last_x) || (item.touch_y != last_y) ||
                         (item.touch_down != is_touched);

  // Pick the touch event type from the previous and new press state
  always_comb begin
    case ({was_touched, item.touch_down})
      2'b01:   touch_type = EV_PRESS;
      2'b10:   touch_type = EV_RELEASE;
      2'b11:   touch_type = EV_HOLD;
      default: touch_type = EV_HOVER;
    endcase
  end

  assign cnt_x2_ext = {8'h00, ring_cnt, 1'b0};

  // Decode one item and work out the next state
  always_comb begin
    cmd_valid_next   = cmd_valid;
    cmd_code_next    = cmd_code;
    arg_count_next   = arg_count;
    read_count_next  = read_count;
    arg_we           = 1'b0;
    ring_rd_next     = ring_rd;
    ring_wr_next     = ring_wr;
    ring_cnt_next    = ring_cnt;
    last_x_next      = last_x;
    last_y_next      = last_y;
    is_touched_next  = is_touched;
    was_touched_next = was_touched;
    push_req         = 1'b0;
    push_data        = '0;
    store_we         = 1'b0;
    ring_we          = 1'b0;
    rd_src           = SRC_DIRECT;
    rd_direct        = 8'h00;

    if (fire) begin
      unique case (item.req_type)
        REQ_START_WRITE: begin
          cmd_valid_next = 1'b0;
          arg_count_next = '0;
        end
        REQ_START_READ: begin
          read_count_next = '0;
        end
        REQ_WRITE_BYTE: begin
          if (!cmd_valid) begin
            // First byte is the command
            cmd_valid_next = 1'b1;
            cmd_code_next  = item.data_byte;
            arg_count_next = '0;
            case (item.data_byte)
              CMD_STATUS_A: begin
                push_req  = 1'b1;
                push_data = make_event(EV_STATUS, ST_STATUS_A);
              end
              CMD_STATUS_B: begin
                push_req  = 1'b1;
                push_data = make_event(EV_STATUS, ST_STATUS_B);
              end
              CMD_STATUS_C: begin
                push_req  = 1'b1;
                push_data = make_event(EV_STATUS, ST_STATUS_C);
              end
              default: ;
            endcase
          end else if (cmd_code == CMD_WINDOW && arg_count >= 17'd2) begin
            // Window data byte into the register store
            if (wpos_ok) begin
              store_we       = 1'b1;
              arg_count_next = sat_inc(arg_count);
            end
          end else if (arg_count < ARG_LIMIT) begin
            arg_we         = 1'b1;
            arg_count_next = arg_count + 17'd1;
            if (cmd_code == CMD_CALIBRATE && arg_count == 17'd1) begin
              push_req  = 1'b1;
              push_data = make_event(EV_CALIBRATED, ST_CALIBRATED);
            end else if (cmd_code == CMD_WRITE_REG && arg_count == 17'd2) begin
              if (arg_bytes[0] == REG_ADDR_HI && arg_bytes[1] == REG_SYS_RESET &&
                  item.data_byte == SYS_RESET_VAL) begin
                push_req  = 1'b1;
                push_data = make_event(EV_READY, 8'h00);
              end
            end else if (cmd_code == CMD_GPIO_QUERY && arg_count == 17'd0) begin
              if (item.data_byte == GPIO_QUERY_ARG) begin
                push_req  = 1'b1;
                push_data = {24'h0, 8'h01, 8'h01, 8'h01, ST_GPIO, EV_GPIO};
              end
            end
          end
        end
        REQ_READ_BYTE: begin
          if (cmd_valid) begin
            if (event_cmd) begin
              // Consume the event on its last byte, then read the ring
              if (read_count[2:0] == 3'd7 && ring_cnt != '0) begin
                if (ring_cnt > RIW'(1)) begin
                  ring_rd_next = idx_inc(ring_rd);
                end
                ring_cnt_next = ring_cnt - 1'b1;
              end
              read_count_next = sat_inc(read_count);
              if (ring_valid[ring_rd_next]) begin
                rd_src = SRC_RING;
              end else if (ring_rd_next == '0 && read_count[2:0] == 3'd0) begin
                rd_direct = EV_READY;
              end
            end else if (cmd_code == CMD_WINDOW && arg_count >= 17'd2) begin
              if (read_count == '0) begin
                read_count_next = 17'd1;
              end else if (rpos_ok) begin
                read_count_next = sat_inc(read_count);
                rd_src          = SRC_STORE;
              end
            end else if (count_read_cmd) begin
              read_count_next = sat_inc(read_count);
              if (read_count == 17'd1) begin
                rd_direct = cnt_x2_ext[7:0];
              end
            end
          end
        end
        REQ_TOUCH: begin
          if (touch_changed) begin
            last_x_next      = item.touch_x;
            last_y_next      = item.touch_y;
            is_touched_next  = item.touch_down;
            was_touched_next = item.touch_down;
            push_req         = 1'b1;
            push_data        = touch_event(touch_type, item.touch_x, item.touch_y,
                                           item.touch_down);
          end
        end
        default: ;
      endcase

      // Push into the ring unless it is full
      if (push_req && ring_cnt < FULL_CNT) begin
        ring_we       = 1'b1;
        ring_wr_next  = idx_inc(ring_wr);
        ring_cnt_next = ring_cnt + 1'b1;
        if (ring_cnt == '0) begin
          ring_rd_next = idx_inc(ring_rd);
        end
      end
    end
  end

  assign pending_ext = {5'b00000, ring_cnt_next};

  assign info = '{src:      rd_src,
                  byte_sel: read_count[2:0],
                  direct:   rd_direct,
                  pending:  pending_ext[4:0]};

  assign store_waddr = wpos[SAW-1:0];
  assign store_wdata = item.data_byte;
  assign store_raddr = rpos[SAW-1:0];
  assign ring_waddr  = ring_wr;
  assign ring_wdata  = push_data;
  assign ring_raddr  = ring_rd_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid   <= 1'b0;
      cmd_code    <= '0;
      arg_count   <= '0;
      read_count  <= '0;
      ring_rd     <= '0;
      ring_wr     <= RIW'(1);
      ring_cnt    <= RIW'(1);
      ring_valid  <= '0;
      last_x      <= '0;
      last_y      <= '0;
      is_touched  <= 1'b0;
      was_touched <= 1'b0;
      for (int i = 0; i < ARG_SLOTS; i++) begin
        arg_bytes[i] <= 8'h00;
      end
    end else begin
      cmd_valid   <= cmd_valid_next;
      cmd_code    <= cmd_code_next;
      arg_count   <= arg_count_next;
      read_count  <= read_count_next;
      ring_rd     <= ring_rd_next;
      ring_wr     <= ring_wr_next;
      ring_cnt    <= ring_cnt_next;
      last_x      <= last_x_next;
      last_y      <= last_y_next;
      is_touched  <= is_touched_next;
      was_touched <= was_touched_next;
      if (arg_we) begin
        arg_bytes[arg_count[AIW-1:0]] <= item.data_byte;
      end
      if (ring_we) begin
        ring_valid[ring_wr] <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/tcit_resp.sv
module tcit_resp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tcit_pkg::resp_info_t info,
  input  logic [7:0]           store_rdata,
  input  logic [63:0]          ring_rdata,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_data
);
  import tcit_pkg::*;

  logic       s1_valid;
  resp_info_t s1_info;
  logic       out_advance;
  logic [7:0] rd_byte;

  // Stall chain back from the output register
  assign out_advance = !out_valid || out_ready;
  assign advance     = !s1_valid || out_advance;

  // Hold the transaction info while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_info <= info;
    end
  end

  // Select the returned byte
  always_comb begin
    case (s1_info.src)
      SRC_RING:  rd_byte = ring_rdata[{s1_info.byte_sel, 3'b000} +: 8];
      SRC_STORE: rd_byte = store_rdata;
      default:   rd_byte = s1_info.direct;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      out_data <= {3'b000, s1_info.pending, rd_byte};
    end
  end

endmodule

// File: hw/rtl/touch_controller_i2c_target_top.sv
// A result passes the input register, response stage and output register. Throughput:
// one item per cycle unless m_axis_tready stalls; the output register and the stall
// chain keep it full. Reset: synchronous, active high. After reset all REG_STORE_BYTES
// store bytes (default 65536) are initialized, one per cycle, with s_axis_tready low.
module touch_controller_i2c_target_top #(
  parameter int EVENT_DEPTH     = tcit_pkg::EVENT_DEPTH_DEF,
  parameter int REG_STORE_BYTES = tcit_pkg::REG_STORE_BYTES_DEF,
  parameter int ARG_SLOTS       = tcit_pkg::ARG_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], touch_x[19:8], touch_y[31:20], touch_down[32], zero[39:33]
  input  logic [39:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], pending_events[12:8], zero[15:13]
  output logic [15:0] m_axis_tdata
);
  import tcit_pkg::*;

  localparam int RIW = $clog2(EVENT_DEPTH);
  localparam int SAW = $clog2(REG_STORE_BYTES);
  localparam logic [SAW-1:0] CLR_LAST = SAW'(REG_STORE_BYTES - 1);

  logic           s0_valid;
  item_t          s0_item;
  logic           accept;
  logic           advance;
  logic           fire;
  resp_info_t     info;

  logic           clr_busy;
  logic [SAW-1:0] clr_addr;

  logic           core_store_we;
  logic [SAW-1:0] core_store_waddr;
  logic [7:0]     core_store_wdata;
  logic [SAW-1:0] store_raddr;
  logic           store_we;
  logic [SAW-1:0] store_waddr;
  logic [7:0]     store_wdata;
  logic [7:0]     store_rdata;

  logic           ring_we;
  logic [RIW-1:0] ring_waddr;
  logic [63:0]    ring_wdata;
  logic [RIW-1:0] ring_raddr;
  logic [63:0]    ring_rdata;

  // Input register
  assign s_axis_tready = !clr_busy && (!s0_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = s0_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!s0_valid || advance) begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_item.req_type   <= s_axis_tuser;
      s0_item.data_byte  <= s_axis_tdata[7:0];
      s0_item.touch_x    <= s_axis_tdata[19:8];
      s0_item.touch_y    <= s_axis_tdata[31:20];
      s0_item.touch_down <= s_axis_tdata[32];
    end
  end

  // Sweep the register store with its power-on contents after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == CLR_LAST) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign store_we    = clr_busy || core_store_we;
  assign store_waddr = clr_busy ? clr_addr : core_store_waddr;
  assign store_wdata = clr_busy ? store_init(16'(clr_addr)) : core_store_wdata;

  tcit_core #(
    .EVENT_DEPTH     (EVENT_DEPTH),
    .REG_STORE_BYTES (REG_STORE_BYTES),
    .ARG_SLOTS       (ARG_SLOTS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (s0_item),
    .info        (info),
    .store_we    (core_store_we),
    .store_waddr (core_store_waddr),
    .store_wdata (core_store_wdata),
    .store_raddr (store_raddr),
    .ring_we     (ring_we),
    .ring_waddr  (ring_waddr),
    .ring_wdata  (ring_wdata),
    .ring_raddr  (ring_raddr)
  );

  tcit_ram #(
    .WIDTH (8),
    .DEPTH (REG_STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (advance),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  tcit_ram #(
    .WIDTH (64),
    .DEPTH (EVENT_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (advance),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  tcit_resp u_resp (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s0_valid),
    .info        (info),
    .store_rdata (store_rdata),
    .ring_rdata  (ring_rdata),
    .advance     (advance),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule
